// ===== rtl/sprite_quad_vertex_gen_unit_macros.svh =====
// Assertion helpers for the sprite quad vertex generator.
// Each macro expects clk and rst_n in scope.
`ifndef SPRITE_QUAD_VERTEX_GEN_UNIT_MACROS_SVH
`define SPRITE_QUAD_VERTEX_GEN_UNIT_MACROS_SVH

// Same-cycle implication
`define SQVG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqvg: same-cycle check failed");

// Next-cycle implication
`define SQVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqvg: next-cycle check failed");

`endif

// ===== rtl/sqvg_pkg.sv =====
package sqvg_pkg;

  // Stream word widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 64;

  // Corner sequencing: six corners, index 0..5
  localparam int          CORNER_W    = 3;
  localparam logic [2:0]  LAST_CORNER = 3'd5;

  // Per-corner template bits, bit j belongs to corner j
  localparam logic [5:0] CORNER_PX = 6'b011100;
  localparam logic [5:0] CORNER_PY = 6'b001101;
  localparam logic [5:0] CORNER_U  = 6'b011100;
  localparam logic [5:0] CORNER_V  = 6'b110010;

  // Fixed-point ones
  localparam int POS_ONE = 4096;
  localparam int TEX_ONE = 16384;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] off_p;
    logic signed [15:0] off_q;
    logic        [15:0] scale;
    logic        [9:0]  angle;
    logic        [5:0]  tile;
    logic               hflip;
    logic               vflip;
    logic               last_sprite;
  } sprite_t;

  // One corner of a sprite, handed from the sequencer to the transform pipe
  typedef struct packed {
    sprite_t                spr;
    logic [CORNER_W-1:0]    corner;
  } corner_word_t;

  // Sequencer status
  typedef struct packed {
    logic                busy;
    logic [CORNER_W-1:0] corner;
  } seq_stat_t;

  typedef struct packed {
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic        [14:0] tex_u;
    logic        [14:0] tex_v;
    logic               quad_last;
    logic               frame_end;
  } vertex_t;

  // Quarter-wave sine in Q1.14: odd degree-9 polynomial, Horner in Q30, t in Q16.
  // Used only to build constant tables at elaboration.
  function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned qw_bits);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned acc;
    longint unsigned r;
    t   = (longint'(k) << 16) >> qw_bits;
    t2  = (t * t) >> 16;
    acc = 64'd172272;
    acc = 64'd5026995    - ((acc * t2) >> 16);
    acc = 64'd85569306   - ((acc * t2) >> 16);
    acc = 64'd693598669  - ((acc * t2) >> 16);
    acc = 64'd1686629713 - ((acc * t2) >> 16);
    r   = (((acc * t) >> 16) + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return 15'(r);
  endfunction

endpackage

// ===== rtl/sqvg_seq.sv =====
module sqvg_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sqvg_pkg::sprite_t     in_spr,
  output logic                  cw_valid,
  input  logic                  cw_ready,
  output sqvg_pkg::corner_word_t cw,
  output sqvg_pkg::seq_stat_t   stat
);
  import sqvg_pkg::*;

  logic                busy_r, busy_nxt;
  logic [CORNER_W-1:0] corner_r, corner_nxt;
  sprite_t             spr_r, spr_nxt;
  logic                at_last;
  logic                dn_acc;
  logic                in_acc;

  // Corner counter: one corner word per cycle while cw_ready is high, next sprite taken on the last corner
  always_comb begin
    at_last    = (corner_r == LAST_CORNER);
    dn_acc     = busy_r && cw_ready;
    in_ready   = !busy_r || (at_last && cw_ready);
    in_acc     = in_valid && in_ready;
    busy_nxt   = busy_r;
    corner_nxt = corner_r;
    spr_nxt    = spr_r;
    if (dn_acc) begin
      if (at_last) begin
        busy_nxt   = 1'b0;
        corner_nxt = '0;
      end else begin
        corner_nxt = corner_r + CORNER_W'(1);
      end
    end
    if (in_acc) begin
      busy_nxt   = 1'b1;
      corner_nxt = '0;
      spr_nxt    = in_spr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      corner_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spr_r <= spr_nxt;
  end

  assign cw_valid    = busy_r;
  assign cw.spr      = spr_r;
  assign cw.corner   = corner_r;
  assign stat.busy   = busy_r;
  assign stat.corner = corner_r;

endmodule

// ===== rtl/sqvg_sine_rom.sv =====
module sqvg_sine_rom #(
  parameter int ANGLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-2:0] addr_s,
  input  logic [ANGLE_BITS-2:0] addr_c,
  output logic [14:0]           data_s,
  output logic [14:0]           data_c
);
  import sqvg_pkg::*;

  localparam int QW      = ANGLE_BITS - 2;
  localparam int QW_SIZE = 1 << QW;

  typedef logic [14:0] sine_tbl_t [QW_SIZE+1];

  function automatic sine_tbl_t build_tbl();
    sine_tbl_t tb;
    for (int i = 0; i <= QW_SIZE; i++) begin
      tb[i] = quarter_sine(i, QW);
    end
    return tb;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_tbl();

  logic [14:0] data_s_r;
  logic [14:0] data_c_r;

  // Two registered read ports, sine and cosine
  always_ff @(posedge clk) begin
    if (en) begin
      data_s_r <= SINE_TBL[addr_s];
      data_c_r <= SINE_TBL[addr_c];
    end
  end

  assign data_s = data_s_r;
  assign data_c = data_c_r;

endmodule

// ===== rtl/sqvg_xform.sv =====
module sqvg_xform #(
  parameter int ATLAS_COLS = 8,
  parameter int ANGLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cw_valid,
  output logic                   cw_ready,
  input  sqvg_pkg::corner_word_t cw,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sqvg_pkg::vertex_t      out_vert
);
  import sqvg_pkg::*;

  localparam int QW      = ANGLE_BITS - 2;
  localparam int QW_SIZE = 1 << QW;
  localparam int AW      = (ANGLE_BITS > 10) ? ANGLE_BITS : 10;
  localparam int CELL    = TEX_ONE / ATLAS_COLS;

  // Atlas cell origins per tile
  typedef logic [19:0] base_tbl_t [64];

  function automatic base_tbl_t build_ubase();
    base_tbl_t tb;
    for (int i = 0; i < 64; i++) begin
      tb[i] = 20'((i % ATLAS_COLS) * CELL);
    end
    return tb;
  endfunction

  function automatic base_tbl_t build_vbase();
    base_tbl_t tb;
    for (int i = 0; i < 64; i++) begin
      tb[i] = 20'((i / ATLAS_COLS) * CELL);
    end
    return tb;
  endfunction

  localparam base_tbl_t UBASE_TBL = build_ubase();
  localparam base_tbl_t VBASE_TBL = build_vbase();

  // Stage handshake
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign cw_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= cw_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // ---------------- stage 1: offset, divide by eight, texture, sine address
  logic [AW-1:0]         ang_ext;
  logic [ANGLE_BITS-1:0] ang_m;
  logic [1:0]            quad_s, quad_c;
  logic [QW-1:0]         k_lo;
  logic [QW:0]           addr_s, addr_c;
  logic signed [16:0]    cx, cy, sum_x, sum_y;
  logic [19:0]           u_full, v_full;
  logic [14:0]           rom_s, rom_c;

  logic signed [13:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic [15:0]        sc1_nxt, sc1_r;
  logic signed [15:0] px1_r, py1_r;
  logic [14:0]        u1_nxt, v1_nxt, u1_r, v1d_r;
  logic               ql1_nxt, fe1_nxt, ql1_r, fe1_r;
  logic               ns1_nxt, nc1_nxt, ns1_r, nc1_r;

  always_comb begin
    ang_ext = AW'(cw.spr.angle);
    ang_m   = ang_ext[ANGLE_BITS-1:0];
    quad_s  = ang_m[ANGLE_BITS-1 -: 2];
    quad_c  = quad_s + 2'd1;
    k_lo    = ang_m[QW-1:0];
    addr_s  = quad_s[0] ? ((QW+1)'(QW_SIZE) - {1'b0, k_lo}) : {1'b0, k_lo};
    addr_c  = quad_c[0] ? ((QW+1)'(QW_SIZE) - {1'b0, k_lo}) : {1'b0, k_lo};
    ns1_nxt = quad_s[1];
    nc1_nxt = quad_c[1];

    cx     = CORNER_PX[cw.corner] ? 17'(POS_ONE) : -17'(POS_ONE);
    cy     = CORNER_PY[cw.corner] ? 17'(POS_ONE) : -17'(POS_ONE);
    sum_x  = 17'(cw.spr.off_p) + cx + 17'sd4;
    sum_y  = 17'(cw.spr.off_q) + cy + 17'sd4;
    dx_nxt = 14'(sum_x >>> 3);
    dy_nxt = 14'(sum_y >>> 3);
    sc1_nxt = cw.spr.scale;

    // mirrored template corner plus cell origin, clamped at one
    u_full = UBASE_TBL[cw.spr.tile] +
             ((CORNER_U[cw.corner] ^ cw.spr.hflip) ? 20'(CELL) : 20'd0);
    v_full = VBASE_TBL[cw.spr.tile] +
             ((CORNER_V[cw.corner] ^ cw.spr.vflip) ? 20'(CELL) : 20'd0);
    u1_nxt = (u_full > 20'(TEX_ONE)) ? 15'(TEX_ONE) : u_full[14:0];
    v1_nxt = (v_full > 20'(TEX_ONE)) ? 15'(TEX_ONE) : v_full[14:0];

    ql1_nxt = (cw.corner == LAST_CORNER);
    fe1_nxt = ql1_nxt && cw.spr.last_sprite;
  end

  sqvg_sine_rom #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (en1),
    .addr_s (addr_s),
    .addr_c (addr_c),
    .data_s (rom_s),
    .data_c (rom_c)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      sc1_r <= sc1_nxt;
      px1_r <= cw.spr.pos_x;
      py1_r <= cw.spr.pos_y;
      u1_r  <= u1_nxt;
      v1d_r <= v1_nxt;
      ql1_r <= ql1_nxt;
      fe1_r <= fe1_nxt;
      ns1_r <= ns1_nxt;
      nc1_r <= nc1_nxt;
    end
  end

  // ---------------- stage 2: scale, signed sine and cosine
  logic signed [30:0] prod_x, prod_y;
  logic signed [16:0] sc_s;
  logic signed [15:0] sn_pos, cs_pos;
  logic signed [18:0] sx_nxt, sy_nxt, sx_r, sy_r;
  logic signed [15:0] sn_nxt, cs_nxt, sn_r, cs_r;
  logic signed [15:0] px2_r, py2_r;
  logic [14:0]        u2_r, v2d_r;
  logic               ql2_r, fe2_r;

  always_comb begin
    sc_s   = signed'({1'b0, sc1_r});
    prod_x = 31'(dx_r) * 31'(sc_s);
    prod_y = 31'(dy_r) * 31'(sc_s);
    sx_nxt = 19'((prod_x + 31'sd2048) >>> 12);
    sy_nxt = 19'((prod_y + 31'sd2048) >>> 12);
    sn_pos = signed'({1'b0, rom_s});
    cs_pos = signed'({1'b0, rom_c});
    sn_nxt = ns1_r ? -sn_pos : sn_pos;
    cs_nxt = nc1_r ? -cs_pos : cs_pos;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sn_r  <= sn_nxt;
      cs_r  <= cs_nxt;
      px2_r <= px1_r;
      py2_r <= py1_r;
      u2_r  <= u1_r;
      v2d_r <= v1d_r;
      ql2_r <= ql1_r;
      fe2_r <= fe1_r;
    end
  end

  // ---------------- stage 3: rotation products
  logic signed [34:0] pcx_nxt, psy_nxt, psx_nxt, pcy_nxt;
  logic signed [34:0] pcx_r, psy_r, psx_r, pcy_r;
  logic signed [15:0] px3_r, py3_r;
  logic [14:0]        u3_r, v3d_r;
  logic               ql3_r, fe3_r;

  always_comb begin
    pcx_nxt = 35'(cs_r) * 35'(sx_r);
    psy_nxt = 35'(sn_r) * 35'(sy_r);
    psx_nxt = 35'(sn_r) * 35'(sx_r);
    pcy_nxt = 35'(cs_r) * 35'(sy_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pcx_r <= pcx_nxt;
      psy_r <= psy_nxt;
      psx_r <= psx_nxt;
      pcy_r <= pcy_nxt;
      px3_r <= px2_r;
      py3_r <= py2_r;
      u3_r  <= u2_r;
      v3d_r <= v2d_r;
      ql3_r <= ql2_r;
      fe3_r <= fe2_r;
    end
  end

  // ---------------- stage 4: combine and round rotation
  logic signed [35:0] rsum_x, rsum_y;
  logic signed [21:0] rx_nxt, ry_nxt, rx_r, ry_r;
  logic signed [15:0] px4_r, py4_r;
  logic [14:0]        u4_r, v4d_r;
  logic               ql4_r, fe4_r;

  always_comb begin
    rsum_x = 36'(pcx_r) - 36'(psy_r) + 36'sd8192;
    rsum_y = 36'(psx_r) + 36'(pcy_r) + 36'sd8192;
    rx_nxt = 22'(rsum_x >>> 14);
    ry_nxt = 22'(rsum_y >>> 14);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      px4_r <= px3_r;
      py4_r <= py3_r;
      u4_r  <= u3_r;
      v4d_r <= v3d_r;
      ql4_r <= ql3_r;
      fe4_r <= fe3_r;
    end
  end

  // ---------------- stage 5: translate, saturate, output register
  logic signed [22:0] tx, ty;
  vertex_t            vert_nxt, vert_r;

  always_comb begin
    tx = 23'(rx_r) + 23'(px4_r);
    ty = 23'(ry_r) + 23'(py4_r);
    if (tx > 23'sd32767)       vert_nxt.vert_x = 16'sh7FFF;
    else if (tx < -23'sd32768) vert_nxt.vert_x = 16'sh8000;
    else                       vert_nxt.vert_x = 16'(tx);
    if (ty > 23'sd32767)       vert_nxt.vert_y = 16'sh7FFF;
    else if (ty < -23'sd32768) vert_nxt.vert_y = 16'sh8000;
    else                       vert_nxt.vert_y = 16'(ty);
    vert_nxt.tex_u     = u4_r;
    vert_nxt.tex_v     = v4d_r;
    vert_nxt.quad_last = ql4_r;
    vert_nxt.frame_end = fe4_r;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      vert_r <= vert_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_vert  = vert_r;

endmodule

// ===== rtl/sprite_quad_vertex_gen_unit.sv =====
// Sprite quad vertex generator.
// Input stream: one word per sprite (position, corner offset, scale, angle,
// atlas tile, flip flags), tlast marks the last sprite of a frame.
// Output stream: six vertex words per sprite in fixed corner order, each with
// Q4.12 position and Q1.14 texture coordinates; tlast marks the sixth vertex
// of every quad, tuser marks the sixth vertex of the frame's last sprite.
// Throughput: one vertex per cycle while out_tready is high, set by the
// corner sequencer that issues one corner per clock into the transform pipe.
// The sequencer loads each sprite at the edge that accepts it, then every
// corner passes through five transform stages, the last being the output register.
// The next sprite is accepted in the cycle its predecessor's last corner
// leaves the sequencer, so consecutive sprites stream without a gap.
// Reset clears the valid bits and the sequencer's busy flag and corner; data registers are not reset.
// When out_tready is low, each stage holds its word and the pipe closes up
// its bubbles; in_tready is high only while the sequencer is idle or hands off its last corner.
module sprite_quad_vertex_gen_unit #(
  parameter int ATLAS_COLS = 8,
  parameter int ANGLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x[15:0] pos_y[31:16] off_p[47:32] off_q[63:48] scale[79:64]
  // angle[89:80] tile[95:90] hflip[96] vflip[97], zero pad above
  input  logic [sqvg_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tlast,   // last_sprite
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // vert_x[15:0] vert_y[31:16] tex_u[46:32] tex_v[61:47], zero pad above
  output logic [sqvg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,  // quad_last
  output logic                              out_tuser   // frame_end
);
  import sqvg_pkg::*;

  sprite_t      in_spr;
  corner_word_t cw;
  logic         cw_valid;
  logic         cw_ready;
  seq_stat_t    seq_stat;
  vertex_t      vert;

  // Unpack the input word
  always_comb begin
    in_spr.pos_x       = in_tdata[15:0];
    in_spr.pos_y       = in_tdata[31:16];
    in_spr.off_p       = in_tdata[47:32];
    in_spr.off_q       = in_tdata[63:48];
    in_spr.scale       = in_tdata[79:64];
    in_spr.angle       = in_tdata[89:80];
    in_spr.tile        = in_tdata[95:90];
    in_spr.hflip       = in_tdata[96];
    in_spr.vflip       = in_tdata[97];
    in_spr.last_sprite = in_tlast;
  end

  sqvg_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_spr   (in_spr),
    .cw_valid (cw_valid),
    .cw_ready (cw_ready),
    .cw       (cw),
    .stat     (seq_stat)
  );

  sqvg_xform #(
    .ATLAS_COLS (ATLAS_COLS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .cw_valid  (cw_valid),
    .cw_ready  (cw_ready),
    .cw        (cw),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_vert  (vert)
  );

  // Pack the output word
  assign out_tdata = {2'b00, vert.tex_v, vert.tex_u, vert.vert_y, vert.vert_x};
  assign out_tlast = vert.quad_last;
  assign out_tuser = vert.frame_end;

  `include "sprite_quad_vertex_gen_unit_macros.svh"

  // Frame end only ever comes with the closing vertex of a quad
  `SQVG_ASSERT_NOW(a_frame_end_on_quad_last, out_tvalid && out_tuser, out_tlast)
  // An accepted sprite starts the sequencer at its first corner
  `SQVG_ASSERT_NEXT(a_seq_starts_corner0, in_tvalid && in_tready, seq_stat.busy && (seq_stat.corner == '0))
  // Texture coordinates are clamped at one
  `SQVG_ASSERT_NOW(a_tex_clamped, out_tvalid, (out_tdata[46:32] <= 15'd16384) && (out_tdata[61:47] <= 15'd16384))

endmodule
